>>> hdl/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// shared types and constants for the swept box overlap test
// ----------------------------------------------------------------------------
`default_nettype none
package sbot_pkg;
   localparam int COORD_BITS_DEF   = 24;
   localparam int TIME_BITS_DEF    = 24;
   localparam int TIME_FRAC        = 16;
   localparam int FRAME_TIME_RESET = 1092;

   typedef struct packed {
      logic live;
      logic moving;
      logic x_ok;
      logic x_ent;
      logic x_ext;
      logic y_ok;
      logic y_ent;
      logic y_ext;
   } flags_type;
endpackage
`default_nettype wire

>>> hdl/sbot_prep.sv
// ----------------------------------------------------------------------------
// sbot_prep
// relative velocity, per-axis distances and case flags, one register stage
// ----------------------------------------------------------------------------
`default_nettype none
module sbot_prep
   import sbot_pkg::*;
#(
   parameter int CW = COORD_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic signed [CW-1:0] a_min_x,
   input  wire logic signed [CW-1:0] a_min_y,
   input  wire logic signed [CW-1:0] a_max_x,
   input  wire logic signed [CW-1:0] a_max_y,
   input  wire logic signed [CW-1:0] b_min_x,
   input  wire logic signed [CW-1:0] b_min_y,
   input  wire logic signed [CW-1:0] b_max_x,
   input  wire logic signed [CW-1:0] b_max_y,
   input  wire logic signed [CW-1:0] a_vel_x,
   input  wire logic signed [CW-1:0] a_vel_y,
   input  wire logic signed [CW-1:0] b_vel_x,
   input  wire logic signed [CW-1:0] b_vel_y,
   output flags_type                 flags,
   output logic [CW-1:0]             dist_xe,
   output logic [CW-1:0]             dist_xx,
   output logic [CW-1:0]             dist_ye,
   output logic [CW-1:0]             dist_yx,
   output logic [CW:0]               speed_x,
   output logic [CW:0]               speed_y
);
   flags_type flags_ff, flags_in;
   logic [CW-1:0] dxe_ff, dxe_in, dxx_ff, dxx_in, dye_ff, dye_in, dyx_ff, dyx_in;
   logic [CW:0] sx_ff, sx_in, sy_ff, sy_in;

   function automatic logic signed [CW:0] sx1(input logic signed [CW-1:0] v);
      sx1 = {v[CW-1], v};
   endfunction

   logic signed [CW:0] vx, vy;
   logic signed [CW:0] bmin_amax_x, bmax_amin_x, amin_bmax_x, amax_bmin_x;
   logic signed [CW:0] bmin_amax_y, bmax_amin_y, amin_bmax_y, amax_bmin_y;

   always_comb begin
      vx = sx1(b_vel_x) - sx1(a_vel_x);
      vy = sx1(b_vel_y) - sx1(a_vel_y);
      bmin_amax_x = sx1(b_min_x) - sx1(a_max_x);
      bmax_amin_x = sx1(b_max_x) - sx1(a_min_x);
      amin_bmax_x = sx1(a_min_x) - sx1(b_max_x);
      amax_bmin_x = sx1(a_max_x) - sx1(b_min_x);
      bmin_amax_y = sx1(b_min_y) - sx1(a_max_y);
      bmax_amin_y = sx1(b_max_y) - sx1(a_min_y);
      amin_bmax_y = sx1(a_min_y) - sx1(b_max_y);
      amax_bmin_y = sx1(a_max_y) - sx1(b_min_y);

      flags_in.live   = take;
      flags_in.moving = (vx != '0) || (vy != '0);

      sx_in = vx[CW] ? (CW+1)'(-vx) : vx;
      sy_in = vy[CW] ? (CW+1)'(-vy) : vy;

      if (vx[CW]) begin
         flags_in.x_ok  = !(a_min_x > b_max_x);
         flags_in.x_ent = a_max_x < b_min_x;
         flags_in.x_ext = a_min_x < b_max_x;
         dxe_in = bmin_amax_x[CW-1:0];
         dxx_in = bmax_amin_x[CW-1:0];
      end else if (vx != '0) begin
         flags_in.x_ok  = !(a_max_x < b_min_x);
         flags_in.x_ent = a_min_x > b_max_x;
         flags_in.x_ext = a_max_x > b_min_x;
         dxe_in = amin_bmax_x[CW-1:0];
         dxx_in = amax_bmin_x[CW-1:0];
      end else begin
         flags_in.x_ok  = !(a_max_x < b_min_x || a_min_x > b_max_x);
         flags_in.x_ent = 1'b0;
         flags_in.x_ext = 1'b0;
         dxe_in = amin_bmax_x[CW-1:0];
         dxx_in = amax_bmin_x[CW-1:0];
      end

      if (vy[CW]) begin
         flags_in.y_ok  = !(a_min_y > b_max_y);
         flags_in.y_ent = a_max_y < b_min_y;
         flags_in.y_ext = a_min_y < b_max_y;
         dye_in = bmin_amax_y[CW-1:0];
         dyx_in = bmax_amin_y[CW-1:0];
      end else if (vy != '0) begin
         flags_in.y_ok  = !(a_max_y < b_min_y);
         flags_in.y_ent = a_min_y > b_max_y;
         flags_in.y_ext = a_max_y > b_min_y;
         dye_in = amin_bmax_y[CW-1:0];
         dyx_in = amax_bmin_y[CW-1:0];
      end else begin
         flags_in.y_ok  = !(a_max_y < b_min_y || a_min_y > b_max_y);
         flags_in.y_ent = 1'b0;
         flags_in.y_ext = 1'b0;
         dye_in = amin_bmax_y[CW-1:0];
         dyx_in = amax_bmin_y[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      dxe_ff <= dxe_in;
      dxx_ff <= dxx_in;
      dye_ff <= dye_in;
      dyx_ff <= dyx_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
   end

   assign flags   = flags_ff;
   assign dist_xe = dxe_ff;
   assign dist_xx = dxx_ff;
   assign dist_ye = dye_ff;
   assign dist_yx = dyx_ff;
   assign speed_x = sx_ff;
   assign speed_y = sy_ff;
endmodule
`default_nettype wire

>>> hdl/sbot_div.sv
// ----------------------------------------------------------------------------
// sbot_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
`default_nettype none
module sbot_div
   import sbot_pkg::*;
#(
   parameter int CW = COORD_BITS_DEF,
   parameter int TB = TIME_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic [CW-1:0] dvd,
   input  wire logic [CW:0]   speed,
   output logic [TB-1:0]      quot
);
   localparam int NW = CW + TIME_FRAC;
   localparam int SW = CW + 1 + TB;
   localparam int W  = (NW > SW) ? NW : SW;

   logic [W-1:0]  rem_ff [TB+1];
   logic [CW:0]   spd_ff [TB+1];
   logic [TB-1:0] q_ff   [TB+1];
   logic          sat_ff [TB+1];

   logic [W-1:0] num_in;
   logic [W-1:0] lim_in;

   always_comb begin
      num_in = W'({dvd, {TIME_FRAC{1'b0}}});
      lim_in = W'(speed) << TB;
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_in;
      spd_ff[0] <= speed;
      q_ff[0]   <= '0;
      sat_ff[0] <= num_in >= lim_in;
   end

   for (genvar i = 0; i < TB; i++) begin : g_stage
      localparam int B = TB - 1 - i;
      logic [W-1:0] shv;
      logic         ge;
      assign shv = W'(spd_ff[i]) << B;
      assign ge  = rem_ff[i] >= shv;
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= ge ? rem_ff[i] - shv : rem_ff[i];
         spd_ff[i+1] <= spd_ff[i];
         q_ff[i+1]   <= {q_ff[i][TB-2:0], ge};
         sat_ff[i+1] <= sat_ff[i];
      end
   end

   assign quot = sat_ff[TB] ? {TB{1'b1}} : q_ff[TB];
endmodule
`default_nettype wire

>>> hdl/sbot_line.sv
// ----------------------------------------------------------------------------
// sbot_line
// fixed delay line that keeps the case flags aligned with the dividers
// ----------------------------------------------------------------------------
`default_nettype none
module sbot_line #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0]      dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff[0] <= '0;
      end else begin
         tap_ff[0] <= din;
      end
   end

   for (genvar i = 1; i < DEPTH; i++) begin : g_tap
      always_ff @(posedge clock) begin
         if (reset) begin
            tap_ff[i] <= '0;
         end else begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
`default_nettype wire

>>> hdl/sbot_resolve.sv
// ----------------------------------------------------------------------------
// sbot_resolve
// clips entry and exit times per axis and forms the hit result, two stages
// ----------------------------------------------------------------------------
`default_nettype none
module sbot_resolve
   import sbot_pkg::*;
#(
   parameter int TB = TIME_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  flags_type          flags,
   input  wire logic [TB-1:0] frame,
   input  wire logic [TB-1:0] t_xe,
   input  wire logic [TB-1:0] t_xx,
   input  wire logic [TB-1:0] t_ye,
   input  wire logic [TB-1:0] t_yx,
   output logic               rsp_valid,
   output logic               rsp_hit
);
   flags_type     fl_ff;
   logic [TB-1:0] tf_ff, tf_in, tl_ff, tl_in, ye_ff, yx_ff;
   logic          okx_ff, okx_in;
   logic          valid_ff, hit_ff, hit_in;
   logic [TB-1:0] tf2, tl2;

   always_comb begin
      tf_in  = flags.x_ent ? t_xe : '0;
      tl_in  = (flags.x_ext && t_xx < frame) ? t_xx : frame;
      okx_in = flags.x_ok && (tf_in <= tl_in);
   end

   always_comb begin
      tf2 = (fl_ff.y_ent && ye_ff > tf_ff) ? ye_ff : tf_ff;
      tl2 = (fl_ff.y_ext && yx_ff < tl_ff) ? yx_ff : tl_ff;
      hit_in = fl_ff.live && fl_ff.moving && okx_ff && fl_ff.y_ok && (tf2 <= tl2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_ff    <= '0;
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         fl_ff    <= flags;
         valid_ff <= fl_ff.live;
         hit_ff   <= hit_in;
      end
      tf_ff  <= tf_in;
      tl_ff  <= tl_in;
      okx_ff <= okx_in;
      ye_ff  <= t_ye;
      yx_ff  <= t_yx;
   end

   assign rsp_valid = valid_ff;
   assign rsp_hit   = hit_ff;
endmodule
`default_nettype wire

>>> hdl/swept_box_overlap_test_top.sv
// ----------------------------------------------------------------------------
// swept_box_overlap_test_top
// swept 2d box collision test, fully pipelined
//
//   channel   ports                        handshake
//   request   start, busy, req_*           start && !busy
//   response  rsp_valid, rsp_hit           rsp_valid, one cycle
//   config    csr_we, csr_wdata            csr_we
//
// one transaction per cycle; a request passes the prep register, the divider
// pipeline with one quotient bit per stage, then the resolve registers
// busy is always low; the response side cannot stall
// synchronous reset clears valid bits and loads frame_time to its default
// ----------------------------------------------------------------------------
`default_nettype none
module swept_box_overlap_test_top
   import sbot_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_a_min_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_min_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_max_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_max_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_min_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_min_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_max_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_max_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_vel_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_vel_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_vel_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_vel_y,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   input  wire logic                         csr_we,
   input  wire logic [TIME_BITS-1:0]         csr_wdata
);
   localparam int CW  = COORD_BITS;
   localparam int TB  = TIME_BITS;
   localparam int DLY = TB + 1;
   localparam int LW  = TB + $bits(flags_type);
   localparam int LAT = TB + 4;

   logic [TB-1:0] frame_ff;
   flags_type     p_flags, d_flags;
   logic [CW-1:0] d_xe, d_xx, d_ye, d_yx;
   logic [CW:0]   s_x, s_y;
   logic [TB-1:0] q_xe, q_xx, q_ye, q_yx, d_frame;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= TB'(FRAME_TIME_RESET);
      end else if (csr_we) begin
         frame_ff <= csr_wdata;
      end
   end

   sbot_prep #(.CW(CW)) u_prep (
      .clock(clock), .reset(reset), .take(start && !busy),
      .a_min_x(req_a_min_x), .a_min_y(req_a_min_y),
      .a_max_x(req_a_max_x), .a_max_y(req_a_max_y),
      .b_min_x(req_b_min_x), .b_min_y(req_b_min_y),
      .b_max_x(req_b_max_x), .b_max_y(req_b_max_y),
      .a_vel_x(req_a_vel_x), .a_vel_y(req_a_vel_y),
      .b_vel_x(req_b_vel_x), .b_vel_y(req_b_vel_y),
      .flags(p_flags),
      .dist_xe(d_xe), .dist_xx(d_xx), .dist_ye(d_ye), .dist_yx(d_yx),
      .speed_x(s_x), .speed_y(s_y)
   );

   sbot_div #(.CW(CW), .TB(TB)) u_div_xe (.clock(clock), .dvd(d_xe), .speed(s_x), .quot(q_xe));
   sbot_div #(.CW(CW), .TB(TB)) u_div_xx (.clock(clock), .dvd(d_xx), .speed(s_x), .quot(q_xx));
   sbot_div #(.CW(CW), .TB(TB)) u_div_ye (.clock(clock), .dvd(d_ye), .speed(s_y), .quot(q_ye));
   sbot_div #(.CW(CW), .TB(TB)) u_div_yx (.clock(clock), .dvd(d_yx), .speed(s_y), .quot(q_yx));

   sbot_line #(.WIDTH(LW), .DEPTH(DLY)) u_line (
      .clock(clock), .reset(reset),
      .din({frame_ff, p_flags}),
      .dout({d_frame, d_flags})
   );

   sbot_resolve #(.TB(TB)) u_resolve (
      .clock(clock), .reset(reset), .flags(d_flags), .frame(d_frame),
      .t_xe(q_xe), .t_xx(q_xx), .t_ye(q_ye), .t_yx(q_yx),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid) else $error("response missing");
   a_hit_valid: assert property (@(posedge clock)
      rsp_hit |-> rsp_valid) else $error("hit without response");
   a_still: assert property (@(posedge clock) disable iff (reset)
      (start && req_a_vel_x == req_b_vel_x && req_a_vel_y == req_b_vel_y)
      |-> ##LAT !rsp_hit) else $error("hit at zero relative velocity");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response after reset");
endmodule
`default_nettype wire
